>>> design/btsp_pkg.sv
package btsp_pkg;

	typedef enum logic [3:0] {
		PH_TAG  = 4'b0001,
		PH_LEN1 = 4'b0010,
		PH_LENX = 4'b0100,
		PH_VAL  = 4'b1000
	} phase_t;

	typedef enum logic [1:0] {
		KIND_TAG   = 2'd0,
		KIND_LEN   = 2'd1,
		KIND_VALUE = 2'd2,
		KIND_ERROR = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ERR_NONE     = 2'd0,
		ERR_TOO_LONG = 2'd1,
		ERR_INDEF    = 2'd2
	} err_t;

	localparam logic [7:0] LEN_INDEF    = 8'h80;
	localparam logic [7:0] LEN_RESERVED = 8'hFF;
	localparam logic [7:0] PRINT_LO     = 8'h20;
	localparam logic [7:0] PRINT_HI     = 8'h7E;
	localparam logic [7:0] DOT_CHAR     = 8'h2E;
	localparam logic [5:0] COLUMNS_RST  = 6'd16;

	typedef struct packed {
		phase_t      phase;
		logic [7:0]  held_tag;
		logic [31:0] len_acc;
		logic [31:0] value_left;
		logic [31:0] offset;
		logic [5:0]  column;
	} state_t;

	typedef struct packed {
		kind_t       byte_kind;
		logic [1:0]  tag_class;
		logic        constructed;
		logic [4:0]  tag_number;
		logic [31:0] value_length;
		logic        header_done;
		logic [31:0] value_offset;
		logic [7:0]  ascii_char;
		logic        line_start;
		logic        last_of_value;
		err_t        error_code;
	} result_t;

endpackage

>>> design/btsp_step.sv
module btsp_step import btsp_pkg::*; #(
	parameter int MAX_LENGTH_BYTES = 4,
	parameter int LW = 3
) (
	input  state_t        st,
	input  logic [LW-1:0] len_left,
	input  logic [7:0]    data_byte,
	input  logic [5:0]    hex_columns,
	output state_t        st_next,
	output logic [LW-1:0] len_left_next,
	output result_t       res
);

	localparam logic [6:0] MAX_N = 7'(MAX_LENGTH_BYTES);

	logic          fin;
	logic [31:0]   fin_len;
	logic [31:0]   acc_shift;
	logic [LW-1:0] left_dec;
	logic [5:0]    cols;
	logic [5:0]    col_cur;
	logic [5:0]    col_inc;

	always_comb begin
		acc_shift = {st.len_acc[23:0], data_byte};
		left_dec  = (len_left != '0) ? len_left - LW'(1) : '0;
		cols      = (hex_columns == 6'd0) ? 6'd1 : hex_columns;
		// A column count left over from a wider setting wraps to zero.
		col_cur   = (st.column >= cols) ? 6'd0 : st.column;
		col_inc   = col_cur + 6'd1;
	end

	always_comb begin
		fin           = 1'b0;
		fin_len       = '0;
		st_next       = st;
		len_left_next = len_left;
		res           = '0;
		res.tag_class   = st.held_tag[7:6];
		res.constructed = st.held_tag[5];
		res.tag_number  = st.held_tag[4:0];

		case (st.phase)
			PH_TAG: begin
				st_next.held_tag = data_byte;
				res.tag_class    = data_byte[7:6];
				res.constructed  = data_byte[5];
				res.tag_number   = data_byte[4:0];
				res.byte_kind    = KIND_TAG;
				st_next.phase    = PH_LEN1;
			end
			PH_LEN1: begin
				res.byte_kind = KIND_LEN;
				if (!data_byte[7]) begin
					fin     = 1'b1;
					fin_len = {24'd0, data_byte};
				end else if (data_byte == LEN_INDEF) begin
					res.byte_kind    = KIND_ERROR;
					res.error_code   = ERR_INDEF;
					st_next.phase    = PH_TAG;
					st_next.len_acc  = '0;
					len_left_next    = '0;
				end else if (data_byte == LEN_RESERVED || data_byte[6:0] > MAX_N) begin
					res.byte_kind    = KIND_ERROR;
					res.error_code   = ERR_TOO_LONG;
					st_next.phase    = PH_TAG;
					st_next.len_acc  = '0;
					len_left_next    = '0;
				end else begin
					len_left_next   = LW'(data_byte[6:0]);
					st_next.len_acc = '0;
					st_next.phase   = PH_LENX;
				end
			end
			PH_LENX: begin
				res.byte_kind = KIND_LEN;
				if (st.len_acc[31:24] != 8'd0) begin
					// Another byte would push significant bits out of 32.
					res.byte_kind   = KIND_ERROR;
					res.error_code  = ERR_TOO_LONG;
					st_next.phase   = PH_TAG;
					st_next.len_acc = '0;
					len_left_next   = '0;
				end else begin
					st_next.len_acc = acc_shift;
					len_left_next   = left_dec;
					if (left_dec == '0) begin
						st_next.len_acc = '0;
						fin             = 1'b1;
						fin_len         = acc_shift;
					end
				end
			end
			PH_VAL: begin
				res.byte_kind    = KIND_VALUE;
				res.value_offset = st.offset;
				res.ascii_char   = (data_byte inside {[PRINT_LO:PRINT_HI]}) ?
					data_byte : DOT_CHAR;
				res.line_start   = (col_cur == 6'd0);
				st_next.column   = (col_inc >= cols) ? 6'd0 : col_inc;
				st_next.offset   = st.offset + 32'd1;
				if (st.value_left <= 32'd1) begin
					res.last_of_value  = 1'b1;
					st_next.value_left = '0;
					st_next.phase      = PH_TAG;
				end else begin
					st_next.value_left = st.value_left - 32'd1;
				end
			end
			default: begin
				st_next.phase = PH_TAG;
			end
		endcase

		if (fin) begin
			res.value_length = fin_len;
			res.header_done  = 1'b1;
			if (fin_len == 32'd0) begin
				res.last_of_value = 1'b1;
				st_next.phase     = PH_TAG;
			end else begin
				st_next.phase      = PH_VAL;
				st_next.value_left = fin_len;
				st_next.offset     = '0;
				st_next.column     = '0;
			end
		end
	end

endmodule

>>> design/ber_tlv_stream_parser.sv
// Streaming BER tag-length-value parser.
// Input channel: data_byte with in_valid/in_ready, one encoded byte per transfer.
// Output channel: one result per input byte with out_valid/out_ready. The result
// classifies the byte as tag, length, value or error, shows the tag fields, the
// decoded length on the byte that completes the header, and for value bytes the
// offset, a printable character, a dump-line start mark and an end-of-value mark.
// The result of a byte is registered on the edge that accepts it and is presented
// right after that edge. Throughput is one byte per cycle while the receiver keeps
// up; the parser state and the result register both update on the transfer.
// When the receiver stalls, the held result stays put and in_ready drops until
// that result is taken; in_ready follows out_ready combinationally.
// The hex_columns register is written through cfg_we/cfg_wdata and should only
// change while no result is outstanding.
// Reset (arst_n low) puts the parser back to expecting a tag byte, clears all
// counters, marks the result register empty and sets hex_columns to 16.
module ber_tlv_stream_parser import btsp_pkg::*; #(
	parameter int MAX_LENGTH_BYTES = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [5:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  byte_kind,
	output logic [1:0]  tag_class,
	output logic        constructed,
	output logic [4:0]  tag_number,
	output logic [31:0] value_length,
	output logic        header_done,
	output logic [31:0] value_offset,
	output logic [7:0]  ascii_char,
	output logic        line_start,
	output logic        last_of_value,
	output logic [1:0]  error_code
);

	localparam int LW = $clog2(MAX_LENGTH_BYTES + 1);

	state_t        st_q;
	state_t        st_next;
	logic [LW-1:0] len_left_q;
	logic [LW-1:0] len_left_next;
	logic [5:0]    hex_columns_q;
	result_t       res;
	result_t       res_q;
	logic          out_valid_q;
	logic          in_fire;

	assign in_ready = !out_valid_q || out_ready;
	assign in_fire  = in_valid && in_ready;

	btsp_step #(
		.MAX_LENGTH_BYTES(MAX_LENGTH_BYTES),
		.LW(LW)
	) u_step (
		.st(st_q),
		.len_left(len_left_q),
		.data_byte(data_byte),
		.hex_columns(hex_columns_q),
		.st_next(st_next),
		.len_left_next(len_left_next),
		.res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.phase      <= PH_TAG;
			st_q.held_tag   <= '0;
			st_q.len_acc    <= '0;
			st_q.value_left <= '0;
			st_q.offset     <= '0;
			st_q.column     <= '0;
			len_left_q      <= '0;
			hex_columns_q   <= COLUMNS_RST;
			out_valid_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				hex_columns_q <= cfg_wdata;
			end
			if (in_fire) begin
				st_q        <= st_next;
				len_left_q  <= len_left_next;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			res_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign byte_kind     = res_q.byte_kind;
	assign tag_class     = res_q.tag_class;
	assign constructed   = res_q.constructed;
	assign tag_number    = res_q.tag_number;
	assign value_length  = res_q.value_length;
	assign header_done   = res_q.header_done;
	assign value_offset  = res_q.value_offset;
	assign ascii_char    = res_q.ascii_char;
	assign line_start    = res_q.line_start;
	assign last_of_value = res_q.last_of_value;
	assign error_code    = res_q.error_code;

endmodule
